@@ src/sensor_weighted_wheel_drive_macros.svh @@
// ----------------------------------------------------------------------------
// sensor weighted wheel drive assertion macros
// shared concurrent assertion forms, clocked on clk_i and quiet in reset
// ----------------------------------------------------------------------------
`ifndef SENSOR_WEIGHTED_WHEEL_DRIVE_MACROS_SVH
`define SENSOR_WEIGHTED_WHEEL_DRIVE_MACROS_SVH

// property must hold at every edge outside reset
`define SWWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition must never be seen outside reset
`define SWWD_ASSERT_NEVER(lbl, cond, msg) \
  `SWWD_ASSERT(lbl, !(cond), msg)

`endif

@@ src/swwd_pkg.sv @@
// ----------------------------------------------------------------------------
// swwd_pkg
// widths, weight table, register codes and shared types of the wheel drive
// ----------------------------------------------------------------------------
package swwd_pkg;

  // scan and result widths
  localparam int NUM_SENS = 8;
  localparam int PROX_W   = 12;
  localparam int SUM_W    = 15;
  localparam int DRV_W    = 14;

  // weighted sums: |sum| < 2^21 for every reading pattern
  localparam int ACC_W    = 22;
  localparam int MAG_W    = ACC_W - 1;

  // division by 200 through a reciprocal, low by at most one
  localparam int DRIVE_DIV = 200;
  localparam int RECIP_W   = 13;
  localparam logic [RECIP_W-1:0] RECIP = 13'd5242;
  localparam int RECIP_SH  = 20;
  localparam int PROD_W    = MAG_W + RECIP_W;
  localparam int QD_W      = 13;

  // limiting: drive magnitude, limit, scaled numerator and quotient
  localparam int MAGD_W = 13;
  localparam int LIM_W  = 12;
  localparam int OFF_W  = 11;
  localparam int NUM_W  = MAGD_W + LIM_W;
  localparam int QUO_W  = 12;

  // configuration port
  localparam int CFG_W = 12;
  localparam int IDX_W = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_SPEED_LIMIT  = 2'd0,
    REG_LEFT_OFFSET  = 2'd1,
    REG_RIGHT_OFFSET = 2'd2
  } reg_idx_e;

  localparam logic [LIM_W-1:0]        SPEED_LIMIT_RST  = 12'd1000;
  localparam logic signed [OFF_W-1:0] LEFT_OFFSET_RST  = 11'sd66;
  localparam logic signed [OFF_W-1:0] RIGHT_OFFSET_RST = 11'sd72;

  // right drive uses entries 0..7, left drive entries 8..15
  localparam logic signed [7:0] WEIGHTS [2*NUM_SENS] = '{
    8'sd17,  8'sd29,  8'sd34,  8'sd10,  8'sd8,   -8'sd38, -8'sd56, -8'sd76,
    -8'sd72, -8'sd58, -8'sd36, 8'sd8,   8'sd10,  8'sd36,  8'sd28,  8'sd18
  };

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef logic [NUM_SENS-1:0][PROX_W-1:0] prox_arr_t;

  // one classified scan
  typedef struct packed {
    logic signed [ACC_W-1:0] lacc;
    logic signed [ACC_W-1:0] racc;
    logic [SUM_W-1:0]        sum;
    logic [PROX_W-1:0]       max;
  } scan_t;

  // queue status seen by both neighbours
  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

  // side data carried alongside the limiting divider
  typedef struct packed {
    logic signed [DRV_W-1:0] drv_l;
    logic signed [DRV_W-1:0] drv_r;
    logic                    need;
    logic [SUM_W-1:0]        sum;
    logic [PROX_W-1:0]       max;
  } side_t;

endpackage

@@ src/sensor_weighted_wheel_drive.sv @@
// ----------------------------------------------------------------------------
// sensor_weighted_wheel_drive
// weighted proximity scan to left and right wheel drive, with limiting
//
//   channel  signals                              moves
//   in       in_valid_i  in_stall_o  prox_*_i     one scan of eight readings
//   out      out_valid_o out_stall_i *_speed_o    drives, reading sum and max
//            sensor_sum_o sensor_max_o
//   cfg      cfg_valid_i cfg_ready_o              register index and data
//            cfg_index_i cfg_data_i
//
// one scan accepted per clock while in_stall_o is low, one result per scan;
// the twelve-stage quotient pipeline of the limiter makes up most of the
// path from accept to result
// after reset: limit 1000, offsets 66 and 72, no clearing pass needed
// a held result freezes the back pipeline; a four-deep queue lets the front
// keep taking scans until it fills
// ----------------------------------------------------------------------------
module sensor_weighted_wheel_drive #(
  parameter int SENSOR_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // scan request
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [swwd_pkg::PROX_W-1:0]        prox_0_i,
  input  logic [swwd_pkg::PROX_W-1:0]        prox_1_i,
  input  logic [swwd_pkg::PROX_W-1:0]        prox_2_i,
  input  logic [swwd_pkg::PROX_W-1:0]        prox_3_i,
  input  logic [swwd_pkg::PROX_W-1:0]        prox_4_i,
  input  logic [swwd_pkg::PROX_W-1:0]        prox_5_i,
  input  logic [swwd_pkg::PROX_W-1:0]        prox_6_i,
  input  logic [swwd_pkg::PROX_W-1:0]        prox_7_i,
  // result request
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [swwd_pkg::DRV_W-1:0]  left_speed_o,
  output logic signed [swwd_pkg::DRV_W-1:0]  right_speed_o,
  output logic [swwd_pkg::SUM_W-1:0]         sensor_sum_o,
  output logic [swwd_pkg::PROX_W-1:0]        sensor_max_o,
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [swwd_pkg::IDX_W-1:0]         cfg_index_i,
  input  logic [swwd_pkg::CFG_W-1:0]         cfg_data_i
);

  logic [swwd_pkg::LIM_W-1:0]         lim_q;
  logic signed [swwd_pkg::OFF_W-1:0]  left_off_q, right_off_q;
  swwd_pkg::prox_arr_t                prox;
  swwd_pkg::qstat_t                   qstat;
  swwd_pkg::scan_t                    push_data, pop_data;
  logic                               push, pop;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q       <= swwd_pkg::SPEED_LIMIT_RST;
      left_off_q  <= swwd_pkg::LEFT_OFFSET_RST;
      right_off_q <= swwd_pkg::RIGHT_OFFSET_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (swwd_pkg::reg_idx_e'(cfg_index_i))
        swwd_pkg::REG_SPEED_LIMIT:  lim_q       <= cfg_data_i[swwd_pkg::LIM_W-1:0];
        swwd_pkg::REG_LEFT_OFFSET:  left_off_q  <= $signed(cfg_data_i[swwd_pkg::OFF_W-1:0]);
        swwd_pkg::REG_RIGHT_OFFSET: right_off_q <= $signed(cfg_data_i[swwd_pkg::OFF_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // gather the readings
  assign prox[0] = prox_0_i;
  assign prox[1] = prox_1_i;
  assign prox[2] = prox_2_i;
  assign prox[3] = prox_3_i;
  assign prox[4] = prox_4_i;
  assign prox[5] = prox_5_i;
  assign prox[6] = prox_6_i;
  assign prox[7] = prox_7_i;

  swwd_front #(
    .SENSOR_BITS (SENSOR_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .prox_i     (prox),
    .qstat_i    (qstat),
    .push_o     (push),
    .scan_o     (push_data)
  );

  swwd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (pop),
    .data_o (pop_data),
    .stat_o (qstat)
  );

  swwd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .qstat_i       (qstat),
    .scan_i        (pop_data),
    .pop_o         (pop),
    .lim_i         (lim_q),
    .left_off_i    (left_off_q),
    .right_off_i   (right_off_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_speed_o  (left_speed_o),
    .right_speed_o (right_speed_o),
    .sensor_sum_o  (sensor_sum_o),
    .sensor_max_o  (sensor_max_o)
  );

endmodule

@@ src/swwd_front.sv @@
// ----------------------------------------------------------------------------
// swwd_front
// takes a scan, forms both weighted sums, reading sum and maximum
// ----------------------------------------------------------------------------
module swwd_front #(
  parameter int SENSOR_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  swwd_pkg::prox_arr_t prox_i,
  input  swwd_pkg::qstat_t    qstat_i,
  output logic                push_o,
  output swwd_pkg::scan_t     scan_o
);

  localparam int RD_W = (SENSOR_BITS < swwd_pkg::PROX_W) ? SENSOR_BITS : swwd_pkg::PROX_W;

  logic                                  vld_q, vld_d;
  logic                                  accept;
  swwd_pkg::scan_t                       scan_q, scan_d;
  logic signed [swwd_pkg::ACC_W-1:0]     lacc, racc;
  logic [swwd_pkg::SUM_W-1:0]            sum;
  logic [swwd_pkg::PROX_W-1:0]           mx;

  // weighted sums, plain sum and running maximum over the scan
  always_comb begin
    logic [RD_W-1:0]                   rd;
    logic signed [swwd_pkg::ACC_W-1:0] rdw;
    lacc = '0;
    racc = '0;
    sum  = '0;
    mx   = '0;
    for (int i = 0; i < swwd_pkg::NUM_SENS; i++) begin
      rd   = prox_i[i][RD_W-1:0];
      rdw  = $signed(swwd_pkg::ACC_W'(rd));
      racc = racc + swwd_pkg::ACC_W'(swwd_pkg::WEIGHTS[i]) * rdw;
      lacc = lacc + swwd_pkg::ACC_W'(swwd_pkg::WEIGHTS[i + swwd_pkg::NUM_SENS]) * rdw;
      sum  = sum + swwd_pkg::SUM_W'(rd);
      if (swwd_pkg::PROX_W'(rd) > mx) begin
        mx = swwd_pkg::PROX_W'(rd);
      end
    end
  end

  // hold the scan until the queue has room
  assign in_stall_o = vld_q & qstat_i.full;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = vld_q & ~qstat_i.full;

  always_comb begin
    vld_d  = vld_q;
    scan_d = scan_q;
    if (push_o) begin
      vld_d = 1'b0;
    end
    if (accept) begin
      vld_d       = 1'b1;
      scan_d.lacc = lacc;
      scan_d.racc = racc;
      scan_d.sum  = sum;
      scan_d.max  = mx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
  end

  assign scan_o = scan_q;

endmodule

@@ src/swwd_queue.sv @@
// ----------------------------------------------------------------------------
// swwd_queue
// short first-in first-out buffer of classified scans
// ----------------------------------------------------------------------------
`include "sensor_weighted_wheel_drive_macros.svh"

module swwd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  swwd_pkg::scan_t  data_i,
  input  logic             pop_i,
  output swwd_pkg::scan_t  data_o,
  output swwd_pkg::qstat_t stat_o
);

  swwd_pkg::scan_t                mem_q [swwd_pkg::QDEPTH];
  logic [swwd_pkg::QPTR_W-1:0]    wptr_q, rptr_q;
  logic [swwd_pkg::QCNT_W-1:0]    count_q;

  assign stat_o.valid = (count_q != '0);
  assign stat_o.full  = (count_q == swwd_pkg::QCNT_W'(swwd_pkg::QDEPTH));
  assign data_o       = mem_q[rptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  `SWWD_ASSERT_NEVER(a_push_full, push_i && stat_o.full, "push into full queue")
  `SWWD_ASSERT_NEVER(a_pop_empty, pop_i && !stat_o.valid, "pop from empty queue")
  `SWWD_ASSERT(a_level, count_q <= swwd_pkg::QCNT_W'(swwd_pkg::QDEPTH), "queue level overrun")

endmodule

@@ src/swwd_div.sv @@
// ----------------------------------------------------------------------------
// swwd_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module swwd_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [swwd_pkg::NUM_W-1:0]   num_i,
  input  logic [swwd_pkg::MAGD_W-1:0]  den_i,
  output logic [swwd_pkg::QUO_W-1:0]   quo_o
);

  localparam int NS = swwd_pkg::QUO_W;

  // the quotient is known to fit in NS bits, so the top of the numerator
  // starts out below the divisor
  logic [swwd_pkg::MAGD_W-1:0] rem_q [NS];
  logic [swwd_pkg::MAGD_W-1:0] rem_d [NS];
  logic [NS-1:0]               low_q [NS];
  logic [NS-1:0]               low_d [NS];
  logic [swwd_pkg::MAGD_W-1:0] den_q [NS];
  logic [swwd_pkg::MAGD_W-1:0] den_d [NS];
  logic [NS-1:0]               quo_q [NS];
  logic [NS-1:0]               quo_d [NS];

  // one compare and subtract per stage
  always_comb begin
    logic [swwd_pkg::MAGD_W-1:0] prem;
    logic [NS-1:0]               plow;
    logic [swwd_pkg::MAGD_W-1:0] pden;
    logic [NS-1:0]               pquo;
    logic [swwd_pkg::MAGD_W:0]   trial;
    logic                        qbit;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        prem = num_i[swwd_pkg::NUM_W-1 -: swwd_pkg::MAGD_W];
        plow = num_i[NS-1:0];
        pden = den_i;
        pquo = '0;
      end else begin
        prem = rem_q[k-1];
        plow = low_q[k-1];
        pden = den_q[k-1];
        pquo = quo_q[k-1];
      end
      trial = {prem, plow[NS-1]};
      qbit  = (trial >= {1'b0, pden});
      if (qbit) begin
        rem_d[k] = swwd_pkg::MAGD_W'(trial - {1'b0, pden});
      end else begin
        rem_d[k] = swwd_pkg::MAGD_W'(trial);
      end
      low_d[k] = {plow[NS-2:0], 1'b0};
      den_d[k] = pden;
      quo_d[k] = {pquo[NS-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        rem_q[k] <= rem_d[k];
        low_q[k] <= low_d[k];
        den_q[k] <= den_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign quo_o = quo_q[NS-1];

endmodule

@@ src/swwd_back.sv @@
// ----------------------------------------------------------------------------
// swwd_back
// divides the sums by 200, adds offsets and limits both drives
// ----------------------------------------------------------------------------
`include "sensor_weighted_wheel_drive_macros.svh"

module swwd_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  swwd_pkg::qstat_t                   qstat_i,
  input  swwd_pkg::scan_t                    scan_i,
  output logic                               pop_o,
  input  logic [swwd_pkg::LIM_W-1:0]         lim_i,
  input  logic signed [swwd_pkg::OFF_W-1:0]  left_off_i,
  input  logic signed [swwd_pkg::OFF_W-1:0]  right_off_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [swwd_pkg::DRV_W-1:0]  left_speed_o,
  output logic signed [swwd_pkg::DRV_W-1:0]  right_speed_o,
  output logic [swwd_pkg::SUM_W-1:0]         sensor_sum_o,
  output logic [swwd_pkg::PROX_W-1:0]        sensor_max_o
);

  localparam int PRE_STG = 5;
  localparam int NS      = swwd_pkg::QUO_W;
  localparam int DW      = swwd_pkg::DRV_W;
  localparam int MW      = swwd_pkg::MAGD_W;

  logic                 adv;
  logic [PRE_STG-1:0]   pre_vld_q;
  logic [NS-1:0]        div_vld_q;
  logic                 out_vld_q;

  // stage 1: magnitudes and reciprocal products
  logic                            s1_sgn_l_q, s1_sgn_r_q;
  logic [swwd_pkg::MAG_W-1:0]      s1_mag_l_q, s1_mag_r_q;
  logic [swwd_pkg::PROD_W-1:0]     s1_prod_l_q, s1_prod_r_q;
  logic [swwd_pkg::SUM_W-1:0]      s1_sum_q;
  logic [swwd_pkg::PROX_W-1:0]     s1_max_q;
  logic [swwd_pkg::MAG_W-1:0]      mag_l, mag_r;

  // stage 2: corrected quotients by 200
  logic                            s2_sgn_l_q, s2_sgn_r_q;
  logic [swwd_pkg::QD_W-1:0]       s2_q_l_q, s2_q_r_q;
  logic [swwd_pkg::SUM_W-1:0]      s2_sum_q;
  logic [swwd_pkg::PROX_W-1:0]     s2_max_q;
  logic [swwd_pkg::QD_W-1:0]       est_l, est_r, q_l, q_r;
  logic [swwd_pkg::MAG_W-1:0]      res_l, res_r, fix_l, fix_r;
  logic                            cor_l, cor_r;

  // stage 3: drives with offsets
  logic signed [DW-1:0]            s3_drv_l_q, s3_drv_r_q;
  logic [swwd_pkg::SUM_W-1:0]      s3_sum_q;
  logic [swwd_pkg::PROX_W-1:0]     s3_max_q;
  logic signed [DW-1:0]            qs_l, qs_r;

  // stage 4: magnitudes, limit check, larger magnitude
  logic signed [DW-1:0]            s4_drv_l_q, s4_drv_r_q;
  logic [MW-1:0]                   s4_la_q, s4_ra_q, s4_m_q;
  logic                            s4_need_q;
  logic [swwd_pkg::SUM_W-1:0]      s4_sum_q;
  logic [swwd_pkg::PROX_W-1:0]     s4_max_q;
  logic [MW-1:0]                   la, ra;

  // stage 5: scaled numerators
  logic [swwd_pkg::NUM_W-1:0]      s5_num_l_q, s5_num_r_q;
  logic [MW-1:0]                   s5_m_q;
  swwd_pkg::side_t                 s5_side_q;

  // divider side data and quotients
  swwd_pkg::side_t                 side_q [NS];
  logic [swwd_pkg::QUO_W-1:0]      quo_l, quo_r;

  // output register
  logic signed [DW-1:0]            out_l_q, out_r_q;
  logic [swwd_pkg::SUM_W-1:0]      out_sum_q;
  logic [swwd_pkg::PROX_W-1:0]     out_max_q;
  logic signed [DW-1:0]            qx_l, qx_r, lim_l, lim_r;

  // the whole pipeline moves unless a finished result is held
  assign adv   = ~(out_vld_q & out_stall_i);
  assign pop_o = adv & qstat_i.valid;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= '0;
      div_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      pre_vld_q <= {pre_vld_q[PRE_STG-2:0], qstat_i.valid};
      div_vld_q <= {div_vld_q[NS-2:0], pre_vld_q[PRE_STG-1]};
      out_vld_q <= div_vld_q[NS-1];
    end
  end

  // stage 1 logic
  assign mag_l = scan_i.lacc[swwd_pkg::ACC_W-1] ? swwd_pkg::MAG_W'(-scan_i.lacc)
                                                : swwd_pkg::MAG_W'(scan_i.lacc);
  assign mag_r = scan_i.racc[swwd_pkg::ACC_W-1] ? swwd_pkg::MAG_W'(-scan_i.racc)
                                                : swwd_pkg::MAG_W'(scan_i.racc);

  // stage 2 logic: estimate is exact or one low
  assign est_l = s1_prod_l_q[swwd_pkg::RECIP_SH +: swwd_pkg::QD_W];
  assign est_r = s1_prod_r_q[swwd_pkg::RECIP_SH +: swwd_pkg::QD_W];
  assign res_l = s1_mag_l_q
               - swwd_pkg::MAG_W'(est_l) * swwd_pkg::MAG_W'(swwd_pkg::DRIVE_DIV);
  assign res_r = s1_mag_r_q
               - swwd_pkg::MAG_W'(est_r) * swwd_pkg::MAG_W'(swwd_pkg::DRIVE_DIV);
  assign cor_l = (res_l >= swwd_pkg::MAG_W'(swwd_pkg::DRIVE_DIV));
  assign cor_r = (res_r >= swwd_pkg::MAG_W'(swwd_pkg::DRIVE_DIV));
  assign q_l   = est_l + swwd_pkg::QD_W'(cor_l);
  assign q_r   = est_r + swwd_pkg::QD_W'(cor_r);
  assign fix_l = cor_l ? res_l - swwd_pkg::MAG_W'(swwd_pkg::DRIVE_DIV) : res_l;
  assign fix_r = cor_r ? res_r - swwd_pkg::MAG_W'(swwd_pkg::DRIVE_DIV) : res_r;

  // stage 3 logic: restore sign
  assign qs_l = s2_sgn_l_q ? -$signed(DW'(s2_q_l_q)) : $signed(DW'(s2_q_l_q));
  assign qs_r = s2_sgn_r_q ? -$signed(DW'(s2_q_r_q)) : $signed(DW'(s2_q_r_q));

  // stage 4 logic
  assign la = s3_drv_l_q[DW-1] ? MW'(-s3_drv_l_q) : MW'(s3_drv_l_q);
  assign ra = s3_drv_r_q[DW-1] ? MW'(-s3_drv_r_q) : MW'(s3_drv_r_q);

  // front stages of the back pipeline
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sgn_l_q  <= scan_i.lacc[swwd_pkg::ACC_W-1];
      s1_sgn_r_q  <= scan_i.racc[swwd_pkg::ACC_W-1];
      s1_mag_l_q  <= mag_l;
      s1_mag_r_q  <= mag_r;
      s1_prod_l_q <= swwd_pkg::PROD_W'(mag_l) * swwd_pkg::PROD_W'(swwd_pkg::RECIP);
      s1_prod_r_q <= swwd_pkg::PROD_W'(mag_r) * swwd_pkg::PROD_W'(swwd_pkg::RECIP);
      s1_sum_q    <= scan_i.sum;
      s1_max_q    <= scan_i.max;

      s2_sgn_l_q  <= s1_sgn_l_q;
      s2_sgn_r_q  <= s1_sgn_r_q;
      s2_q_l_q    <= q_l;
      s2_q_r_q    <= q_r;
      s2_sum_q    <= s1_sum_q;
      s2_max_q    <= s1_max_q;

      s3_drv_l_q  <= qs_l + DW'(left_off_i);
      s3_drv_r_q  <= qs_r + DW'(right_off_i);
      s3_sum_q    <= s2_sum_q;
      s3_max_q    <= s2_max_q;

      s4_drv_l_q  <= s3_drv_l_q;
      s4_drv_r_q  <= s3_drv_r_q;
      s4_la_q     <= la;
      s4_ra_q     <= ra;
      s4_m_q      <= (la > ra) ? la : ra;
      s4_need_q   <= (la > MW'(lim_i)) | (ra > MW'(lim_i));
      s4_sum_q    <= s3_sum_q;
      s4_max_q    <= s3_max_q;

      s5_num_l_q      <= swwd_pkg::NUM_W'(s4_la_q) * swwd_pkg::NUM_W'(lim_i);
      s5_num_r_q      <= swwd_pkg::NUM_W'(s4_ra_q) * swwd_pkg::NUM_W'(lim_i);
      s5_m_q          <= s4_m_q;
      s5_side_q.drv_l <= s4_drv_l_q;
      s5_side_q.drv_r <= s4_drv_r_q;
      s5_side_q.need  <= s4_need_q;
      s5_side_q.sum   <= s4_sum_q;
      s5_side_q.max   <= s4_max_q;
    end
  end

  // proportional limiting: |drive| * limit / larger magnitude
  swwd_div u_div_l (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (s5_num_l_q),
    .den_i (s5_m_q),
    .quo_o (quo_l)
  );

  swwd_div u_div_r (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (s5_num_r_q),
    .den_i (s5_m_q),
    .quo_o (quo_r)
  );

  // side data follows the divider stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= s5_side_q;
      for (int k = 1; k < NS; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // output selection
  assign qx_l  = $signed(DW'(quo_l));
  assign qx_r  = $signed(DW'(quo_r));
  assign lim_l = side_q[NS-1].drv_l[DW-1] ? -qx_l : qx_l;
  assign lim_r = side_q[NS-1].drv_r[DW-1] ? -qx_r : qx_r;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_l_q   <= side_q[NS-1].need ? lim_l : side_q[NS-1].drv_l;
      out_r_q   <= side_q[NS-1].need ? lim_r : side_q[NS-1].drv_r;
      out_sum_q <= side_q[NS-1].sum;
      out_max_q <= side_q[NS-1].max;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign left_speed_o  = out_l_q;
  assign right_speed_o = out_r_q;
  assign sensor_sum_o  = out_sum_q;
  assign sensor_max_o  = out_max_q;

  `SWWD_ASSERT(a_freeze, !adv |=> $stable({pre_vld_q, div_vld_q, out_vld_q}), "pipeline moved under stall")
  `SWWD_ASSERT(a_res_l, pre_vld_q[0] |-> (fix_l < swwd_pkg::MAG_W'(swwd_pkg::DRIVE_DIV)), "left remainder by 200 out of range")
  `SWWD_ASSERT(a_res_r, pre_vld_q[0] |-> (fix_r < swwd_pkg::MAG_W'(swwd_pkg::DRIVE_DIV)), "right remainder by 200 out of range")

endmodule
